[sv/tsmdf_pkg.sv]
// Package for the timestamp-ordered dual ring FIFO.
// Holds field widths, operation and status codes shared by the interfaces and the top level.
// Depends on nothing.
package tsmdf_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned STAMP_W  = 33;
  localparam int unsigned TAG_W    = 16;
  localparam int unsigned SLOT_W   = 5;
  localparam int unsigned STATUS_W = 2;

  // Operation codes carried in an input transaction.
  typedef enum logic [OP_W-1:0] {
    OP_PUSH_VIDEO = 2'd0,
    OP_PUSH_AUDIO = 2'd1,
    OP_TAKE       = 2'd2
  } op_e;

  // Status codes returned in an output transaction.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

endpackage

[sv/tsmdf_if.sv]
// Valid/ready channel interfaces for the timestamp-ordered dual ring FIFO.
// Depends on tsmdf_pkg for the payload widths.
interface tsmdf_in_if;
  logic                                valid;
  logic                                ready;
  logic [tsmdf_pkg::OP_W-1:0]          op;
  logic [tsmdf_pkg::STAMP_W-1:0]       stamp;
  logic [tsmdf_pkg::TAG_W-1:0]         tag;

  modport source (output valid, output op, output stamp, output tag, input ready);
  modport sink   (input valid, input op, input stamp, input tag, output ready);
endinterface

interface tsmdf_out_if;
  logic                                valid;
  logic                                ready;
  logic [tsmdf_pkg::STATUS_W-1:0]      status;
  logic                                from_video;
  logic [tsmdf_pkg::SLOT_W-1:0]        slot;
  logic [tsmdf_pkg::STAMP_W-1:0]       out_stamp;
  logic [tsmdf_pkg::TAG_W-1:0]         out_tag;

  modport source (output valid, output status, output from_video, output slot,
                  output out_stamp, output out_tag, input ready);
  modport sink   (input valid, input status, input from_video, input slot,
                  input out_stamp, input out_tag, output ready);
endinterface

[sv/tsmdf_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// Depends on nothing.
module tsmdf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/timestamp_merged_dual_fifo_top.sv]
// Top level of the timestamp-ordered dual ring FIFO.
// Depends on tsmdf_pkg, the channel interfaces in tsmdf_if and the RAM in tsmdf_ram.

// Two ring FIFOs, video and audio, each hold descriptors of a 33-bit timestamp and a
// 16-bit tag in a RAM of its own with a registered read. A push transaction writes
// the chosen ring and answers in the next cycle with the slot it used, or with a full
// status when the ring already holds DEPTH-1 entries. A take transaction reads both
// ring heads from the RAMs and then, in the S_TAKE state, compares the heads, picks
// the earlier timestamp (video wins ties) and advances that read pointer. One
// transaction is in progress at a time, and a new one is accepted as soon as the
// output register is free or being emptied. Op code three behaves as a take. Slot
// numbers are the low five bits of the ring index. The RAMs need no clearing after
// reset.
module timestamp_merged_dual_fifo_top #(
  parameter int unsigned VIDEO_DEPTH = 32,
  parameter int unsigned AUDIO_DEPTH = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  tsmdf_in_if.sink       in_i,
  tsmdf_out_if.source    out_o
);

  localparam int unsigned VPW    = $clog2(VIDEO_DEPTH);
  localparam int unsigned APW    = $clog2(AUDIO_DEPTH);
  localparam int unsigned ENT_W  = tsmdf_pkg::STAMP_W + tsmdf_pkg::TAG_W;
  localparam int unsigned VEXT_W = (VPW > tsmdf_pkg::SLOT_W) ? VPW : tsmdf_pkg::SLOT_W;
  localparam int unsigned AEXT_W = (APW > tsmdf_pkg::SLOT_W) ? APW : tsmdf_pkg::SLOT_W;

  typedef enum logic {
    S_IDLE,
    S_TAKE
  } state_e;

  state_e                          state_q;
  logic [VPW-1:0]                  vwr_q, vrd_q;
  logic [APW-1:0]                  awr_q, ard_q;
  logic                            out_valid_q;
  logic [tsmdf_pkg::STATUS_W-1:0]  status_q;
  logic                            from_video_q;
  logic [tsmdf_pkg::SLOT_W-1:0]    slot_q;
  logic [tsmdf_pkg::STAMP_W-1:0]   out_stamp_q;
  logic [tsmdf_pkg::TAG_W-1:0]     out_tag_q;

  logic                            accept;
  logic                            out_load;
  logic                            is_push_v, is_push_a, is_take;
  logic [VPW-1:0]                  vwr_nxt, vrd_nxt;
  logic [APW-1:0]                  awr_nxt, ard_nxt;
  logic                            v_full, a_full, have_v, have_a, take_video;
  logic [ENT_W-1:0]                v_rdata, a_rdata;
  logic [tsmdf_pkg::STAMP_W-1:0]   v_stamp, a_stamp;
  logic [tsmdf_pkg::TAG_W-1:0]     v_tag, a_tag;
  logic [VEXT_W-1:0]               vwr_ext, vrd_ext;
  logic [AEXT_W-1:0]               awr_ext, ard_ext;

  // Handshake: accept only when idle and the output register is free or being emptied this cycle.
  assign in_i.ready = (state_q == S_IDLE) && (!out_valid_q || out_o.ready);
  assign accept     = in_i.valid && in_i.ready;

  // The output register loads after an accepted push and in the S_TAKE state of a take.
  assign out_load   = (state_q == S_TAKE) || (accept && !is_take);

  // Decode: the high op bit selects a take.
  always_comb begin
    is_push_v = 1'b0;
    is_push_a = 1'b0;
    is_take   = 1'b0;
    unique case (in_i.op)
      tsmdf_pkg::OP_PUSH_VIDEO: is_push_v = 1'b1;
      tsmdf_pkg::OP_PUSH_AUDIO: is_push_a = 1'b1;
      default:                  is_take   = 1'b1;
    endcase
  end

  // Ring pointer arithmetic with wrap at the configured depth.
  assign vwr_nxt = (vwr_q == VPW'(VIDEO_DEPTH - 1)) ? '0 : VPW'(vwr_q + VPW'(1));
  assign vrd_nxt = (vrd_q == VPW'(VIDEO_DEPTH - 1)) ? '0 : VPW'(vrd_q + VPW'(1));
  assign awr_nxt = (awr_q == APW'(AUDIO_DEPTH - 1)) ? '0 : APW'(awr_q + APW'(1));
  assign ard_nxt = (ard_q == APW'(AUDIO_DEPTH - 1)) ? '0 : APW'(ard_q + APW'(1));
  assign v_full  = (vwr_nxt == vrd_q);
  assign a_full  = (awr_nxt == ard_q);
  assign have_v  = (vwr_q != vrd_q);
  assign have_a  = (awr_q != ard_q);

  // Slot numbers are the low bits of the zero-extended ring index.
  assign vwr_ext = VEXT_W'(vwr_q);
  assign vrd_ext = VEXT_W'(vrd_q);
  assign awr_ext = AEXT_W'(awr_q);
  assign ard_ext = AEXT_W'(ard_q);

  // Entry stores, one RAM per ring.
  tsmdf_ram #(
    .WIDTH (ENT_W),
    .DEPTH (VIDEO_DEPTH)
  ) u_video_ram (
    .clk_i   (clk_i),
    .we_i    (accept && is_push_v && !v_full),
    .waddr_i (vwr_q),
    .wdata_i ({in_i.stamp, in_i.tag}),
    .re_i    (accept && is_take),
    .raddr_i (vrd_q),
    .rdata_o (v_rdata)
  );

  tsmdf_ram #(
    .WIDTH (ENT_W),
    .DEPTH (AUDIO_DEPTH)
  ) u_audio_ram (
    .clk_i   (clk_i),
    .we_i    (accept && is_push_a && !a_full),
    .waddr_i (awr_q),
    .wdata_i ({in_i.stamp, in_i.tag}),
    .re_i    (accept && is_take),
    .raddr_i (ard_q),
    .rdata_o (a_rdata)
  );

  assign {v_stamp, v_tag} = v_rdata;
  assign {a_stamp, a_tag} = a_rdata;

  // Head selection: the earlier timestamp wins, video on a tie.
  assign take_video = have_v && (!have_a || !(a_stamp < v_stamp));

  // Control state, pointers and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      vwr_q        <= '0;
      vrd_q        <= '0;
      awr_q        <= '0;
      ard_q        <= '0;
      out_valid_q  <= 1'b0;
      status_q     <= tsmdf_pkg::ST_OK;
      from_video_q <= 1'b0;
      slot_q       <= '0;
      out_stamp_q  <= '0;
      out_tag_q    <= '0;
    end else begin
      // The output register fills with a new answer or drains when the receiver takes it.
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept && is_take) begin
            state_q <= S_TAKE;
          end else if (accept) begin
            out_stamp_q  <= '0;
            out_tag_q    <= '0;
            from_video_q <= is_push_v;
            if (is_push_v) begin
              if (v_full) begin
                status_q <= tsmdf_pkg::ST_FULL;
                slot_q   <= '0;
              end else begin
                status_q <= tsmdf_pkg::ST_OK;
                slot_q   <= vwr_ext[tsmdf_pkg::SLOT_W-1:0];
                vwr_q    <= vwr_nxt;
              end
            end else begin
              if (a_full) begin
                status_q <= tsmdf_pkg::ST_FULL;
                slot_q   <= '0;
              end else begin
                status_q <= tsmdf_pkg::ST_OK;
                slot_q   <= awr_ext[tsmdf_pkg::SLOT_W-1:0];
                awr_q    <= awr_nxt;
              end
            end
          end
        end
        S_TAKE: begin
          state_q <= S_IDLE;
          if (!have_v && !have_a) begin
            status_q     <= tsmdf_pkg::ST_EMPTY;
            from_video_q <= 1'b0;
            slot_q       <= '0;
            out_stamp_q  <= '0;
            out_tag_q    <= '0;
          end else if (take_video) begin
            status_q     <= tsmdf_pkg::ST_OK;
            from_video_q <= 1'b1;
            slot_q       <= vrd_ext[tsmdf_pkg::SLOT_W-1:0];
            out_stamp_q  <= v_stamp;
            out_tag_q    <= v_tag;
            vrd_q        <= vrd_nxt;
          end else begin
            status_q     <= tsmdf_pkg::ST_OK;
            from_video_q <= 1'b0;
            slot_q       <= ard_ext[tsmdf_pkg::SLOT_W-1:0];
            out_stamp_q  <= a_stamp;
            out_tag_q    <= a_tag;
            ard_q        <= ard_nxt;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = status_q;
  assign out_o.from_video = from_video_q;
  assign out_o.slot       = slot_q;
  assign out_o.out_stamp  = out_stamp_q;
  assign out_o.out_tag    = out_tag_q;

endmodule

[verif/tsmdf_order_checker.sv]
// Scoreboard for the timestamp-ordered dual ring FIFO: it watches both channels and predicts each answer.
// It compares every output transaction, field by field, with the oldest prediction.
// Depends on tsmdf_pkg and the channel interfaces in tsmdf_if.
module tsmdf_order_checker #(
  parameter int unsigned VIDEO_DEPTH = 32,
  parameter int unsigned AUDIO_DEPTH = 32
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  tsmdf_in_if   in_mon,
  tsmdf_out_if  out_mon,
  output int    error_count_o,
  output int    pending_o
);

  localparam int unsigned OP_W    = tsmdf_pkg::OP_W;
  localparam int unsigned SLOT_W  = tsmdf_pkg::SLOT_W;
  localparam int unsigned STAMP_W = tsmdf_pkg::STAMP_W;
  localparam int unsigned TAG_W   = tsmdf_pkg::TAG_W;

  // One predicted answer of the block.
  typedef struct {
    tsmdf_pkg::status_e   status;
    logic                 from_video;
    logic [SLOT_W-1:0]    slot;
    logic [STAMP_W-1:0]   stamp;
    logic [TAG_W-1:0]     tag;
  } desc_answer_t;

  // Shadow copy of both rings.
  logic [STAMP_W-1:0] video_stamp_q [VIDEO_DEPTH];
  logic [TAG_W-1:0]   video_tag_q   [VIDEO_DEPTH];
  logic [STAMP_W-1:0] audio_stamp_q [AUDIO_DEPTH];
  logic [TAG_W-1:0]   audio_tag_q   [AUDIO_DEPTH];
  int unsigned        video_wr, video_rd, audio_wr, audio_rd;

  desc_answer_t       expected_answers [$];

  function automatic int unsigned ring_next(int unsigned ptr, int unsigned depth);
    return (ptr + 1 >= depth) ? 0 : ptr + 1;
  endfunction

  // Applies one transaction to the shadow rings and returns the answer it must produce.
  function automatic desc_answer_t merge_step(logic [OP_W-1:0] op, logic [STAMP_W-1:0] stamp,
                                              logic [TAG_W-1:0] tag);
    desc_answer_t ans;
    int unsigned  nxt;
    logic         have_video, have_audio, take_video;
    ans = '{status: tsmdf_pkg::ST_OK, from_video: 1'b0, slot: '0, stamp: '0, tag: '0};
    if (op == tsmdf_pkg::OP_PUSH_VIDEO) begin
      nxt = ring_next(video_wr, VIDEO_DEPTH);
      ans.from_video = 1'b1;
      if (nxt == video_rd) begin
        ans.status = tsmdf_pkg::ST_FULL;
      end else begin
        ans.slot = SLOT_W'(video_wr);
        video_stamp_q[video_wr] = stamp;
        video_tag_q[video_wr]   = tag;
        video_wr = nxt;
      end
    end else if (op == tsmdf_pkg::OP_PUSH_AUDIO) begin
      nxt = ring_next(audio_wr, AUDIO_DEPTH);
      if (nxt == audio_rd) begin
        ans.status = tsmdf_pkg::ST_FULL;
      end else begin
        ans.slot = SLOT_W'(audio_wr);
        audio_stamp_q[audio_wr] = stamp;
        audio_tag_q[audio_wr]   = tag;
        audio_wr = nxt;
      end
    end else begin
      // Any op with the high bit set is a take of the earlier head.
      have_video = (video_wr != video_rd);
      have_audio = (audio_wr != audio_rd);
      if (!have_video && !have_audio) begin
        ans.status = tsmdf_pkg::ST_EMPTY;
      end else begin
        if (have_video && have_audio) begin
          // Video wins when the stamps are equal.
          take_video = !(audio_stamp_q[audio_rd] < video_stamp_q[video_rd]);
        end else begin
          take_video = have_video;
        end
        if (take_video) begin
          ans.from_video = 1'b1;
          ans.slot  = SLOT_W'(video_rd);
          ans.stamp = video_stamp_q[video_rd];
          ans.tag   = video_tag_q[video_rd];
          video_rd  = ring_next(video_rd, VIDEO_DEPTH);
        end else begin
          ans.slot  = SLOT_W'(audio_rd);
          ans.stamp = audio_stamp_q[audio_rd];
          ans.tag   = audio_tag_q[audio_rd];
          audio_rd  = ring_next(audio_rd, AUDIO_DEPTH);
        end
      end
    end
    return ans;
  endfunction

  // Compare output transactions first, then record the prediction for an input transaction.
  always @(posedge clk_i or negedge rst_ni) begin
    desc_answer_t want;
    if (!rst_ni) begin
      video_wr = 0;
      video_rd = 0;
      audio_wr = 0;
      audio_rd = 0;
      expected_answers.delete();
      pending_o = 0;
      error_count_o = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_answers.size() == 0) begin
          $error("output transaction with nothing outstanding: status %0d, slot %0d",
                 out_mon.status, out_mon.slot);
          error_count_o++;
        end else begin
          want = expected_answers.pop_front();
          if (out_mon.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_mon.status);
            error_count_o++;
          end
          if (out_mon.from_video !== want.from_video) begin
            $error("from_video: expected %0d, actual %0d", want.from_video, out_mon.from_video);
            error_count_o++;
          end
          if (out_mon.slot !== want.slot) begin
            $error("slot: expected %0d, actual %0d", want.slot, out_mon.slot);
            error_count_o++;
          end
          if (out_mon.out_stamp !== want.stamp) begin
            $error("out_stamp: expected 0x%0h, actual 0x%0h", want.stamp, out_mon.out_stamp);
            error_count_o++;
          end
          if (out_mon.out_tag !== want.tag) begin
            $error("out_tag: expected 0x%0h, actual 0x%0h", want.tag, out_mon.out_tag);
            error_count_o++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_answers.push_back(merge_step(in_mon.op, in_mon.stamp, in_mon.tag));
      end
      pending_o = expected_answers.size();
    end
  end

endmodule

[verif/tb_timestamp_merged_dual_fifo_top.sv]
// Testbench top for the timestamp-ordered dual ring FIFO: clock, reset, stimulus and verdict.
// Prediction and comparison live in tsmdf_order_checker.
// Depends on tsmdf_pkg, tsmdf_if, the block and the checker.
module tb_timestamp_merged_dual_fifo_top;

  localparam int unsigned VIDEO_DEPTH    = 32;
  localparam int unsigned AUDIO_DEPTH    = 32;
  localparam int unsigned NUM_PHASES     = 18;
  localparam int unsigned PHASE_ITEMS    = 80;
  localparam int unsigned RX_HOLD_CYCLES = 300;
  localparam int unsigned QUIET_LIMIT    = 2000;
  localparam int unsigned TAIL_CYCLES    = 10;
  localparam int unsigned IDLE_PERCENT   = 20;

  localparam int unsigned OP_W    = tsmdf_pkg::OP_W;
  localparam int unsigned STAMP_W = tsmdf_pkg::STAMP_W;
  localparam int unsigned TAG_W   = tsmdf_pkg::TAG_W;

  // Op code three is unused but decodes as a take.
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  // Traffic mix of one random phase.
  typedef enum int {
    PH_FILL_VIDEO,
    PH_FILL_AUDIO,
    PH_DRAIN,
    PH_MIXED
  } phase_kind_e;

  logic clk_i;
  logic rst_ni;
  logic no_idle     = 1'b0;
  logic rx_hold_req = 1'b0;
  int   errors;
  int   pending;

  tsmdf_in_if  in_ch ();
  tsmdf_out_if out_ch ();

  timestamp_merged_dual_fifo_top #(
    .VIDEO_DEPTH (VIDEO_DEPTH),
    .AUDIO_DEPTH (AUDIO_DEPTH)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  tsmdf_order_checker #(
    .VIDEO_DEPTH (VIDEO_DEPTH),
    .AUDIO_DEPTH (AUDIO_DEPTH)
  ) i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .error_count_o (errors),
    .pending_o     (pending)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Offers one input transaction at the falling edge and waits until it is taken.
  task automatic offer_descriptor(input logic [OP_W-1:0] op, input logic [STAMP_W-1:0] stamp,
                                  input logic [TAG_W-1:0] tag);
    @(negedge clk_i);
    while (!no_idle && $urandom_range(99, 0) < IDLE_PERCENT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.op    <= op;
    in_ch.stamp <= stamp;
    in_ch.tag   <= tag;
    do @(posedge clk_i); while (!(in_ch.valid && in_ch.ready));
  endtask

  // Many stamps come from a narrow range so that equal heads are common.
  function automatic logic [STAMP_W-1:0] pick_stamp();
    int unsigned r;
    r = $urandom_range(9, 0);
    if (r < 4) return STAMP_W'($urandom_range(15, 0));
    if (r < 6) begin
      case ($urandom_range(3, 0))
        0:       return '0;
        1:       return STAMP_W'(1);
        2:       return {{(STAMP_W-1){1'b1}}, 1'b0};
        default: return '1;
      endcase
    end
    return {1'($urandom_range(1, 0)), 32'($urandom())};
  endfunction

  function automatic logic [TAG_W-1:0] pick_tag();
    if ($urandom_range(9, 0) < 2) return $urandom_range(1, 0) ? '1 : '0;
    return TAG_W'($urandom_range(65535, 0));
  endfunction

  // Fill phases lean on one ring so that it runs full; drain phases empty both rings.
  function automatic logic [OP_W-1:0] pick_op(phase_kind_e kind);
    int unsigned      r;
    logic [OP_W-1:0]  take_op;
    r = $urandom_range(99, 0);
    take_op = ($urandom_range(3, 0) == 0) ? OP_SPARE : tsmdf_pkg::OP_TAKE;
    case (kind)
      PH_FILL_VIDEO: return (r < 75) ? tsmdf_pkg::OP_PUSH_VIDEO :
                            (r < 85) ? tsmdf_pkg::OP_PUSH_AUDIO : take_op;
      PH_FILL_AUDIO: return (r < 75) ? tsmdf_pkg::OP_PUSH_AUDIO :
                            (r < 85) ? tsmdf_pkg::OP_PUSH_VIDEO : take_op;
      PH_DRAIN:      return (r < 15) ? tsmdf_pkg::OP_PUSH_VIDEO :
                            (r < 30) ? tsmdf_pkg::OP_PUSH_AUDIO : take_op;
      default:       return (r < 35) ? tsmdf_pkg::OP_PUSH_VIDEO :
                            (r < 70) ? tsmdf_pkg::OP_PUSH_AUDIO : take_op;
    endcase
  endfunction

  // Receiver: random back-pressure, or a long hold-off when one is requested.
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES - 1) begin
          @(negedge clk_i);
          out_ch.ready <= 1'b0;
        end
      end else begin
        out_ch.ready <= no_idle || ($urandom_range(99, 0) >= IDLE_PERCENT);
      end
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  initial begin
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    in_ch.valid = 1'b0;
    in_ch.op    = tsmdf_pkg::OP_PUSH_VIDEO;
    in_ch.stamp = '0;
    in_ch.tag   = '0;
    rst_ni      = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Takes on empty rings, including the spare op code.
    offer_descriptor(tsmdf_pkg::OP_TAKE, '0, '0);
    offer_descriptor(OP_SPARE, '1, '1);
    // Field extremes; the video ring drains first, its second head winning a tie on the largest stamp.
    offer_descriptor(tsmdf_pkg::OP_PUSH_VIDEO, '0, '0);
    offer_descriptor(tsmdf_pkg::OP_PUSH_VIDEO, '1, '1);
    offer_descriptor(tsmdf_pkg::OP_PUSH_AUDIO, '1, '1);
    offer_descriptor(tsmdf_pkg::OP_PUSH_AUDIO, '0, '0);
    offer_descriptor(tsmdf_pkg::OP_TAKE, '0, '0);
    offer_descriptor(tsmdf_pkg::OP_TAKE, '0, '0);
    offer_descriptor(tsmdf_pkg::OP_TAKE, '0, '0);
    offer_descriptor(tsmdf_pkg::OP_TAKE, '0, '0);
    // Equal heads: video goes first.
    offer_descriptor(tsmdf_pkg::OP_PUSH_AUDIO, STAMP_W'(5), 16'h1234);
    offer_descriptor(tsmdf_pkg::OP_PUSH_VIDEO, STAMP_W'(5), 16'h4321);
    offer_descriptor(tsmdf_pkg::OP_TAKE, '0, '0);
    offer_descriptor(tsmdf_pkg::OP_TAKE, '0, '0);
    // Earlier audio head wins over a later video head.
    offer_descriptor(tsmdf_pkg::OP_PUSH_VIDEO, STAMP_W'(100), 16'hAAAA);
    offer_descriptor(tsmdf_pkg::OP_PUSH_AUDIO, STAMP_W'(50), 16'h5555);
    offer_descriptor(OP_SPARE, '0, '0);
    offer_descriptor(tsmdf_pkg::OP_TAKE, '0, '0);
    // Alternating bit patterns in every field.
    offer_descriptor(tsmdf_pkg::OP_PUSH_AUDIO, 33'h155555555, 16'hAAAA);
    offer_descriptor(tsmdf_pkg::OP_PUSH_VIDEO, 33'h0AAAAAAAA, 16'h5555);
    offer_descriptor(tsmdf_pkg::OP_TAKE, '0, '0);
    offer_descriptor(tsmdf_pkg::OP_TAKE, '0, '0);
    offer_descriptor(tsmdf_pkg::OP_TAKE, '0, '0);

    // Random phases cycling through fill, drain and mixed traffic.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      no_idle = (ph >= 10 && ph <= 12);
      if (ph == 4) rx_hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        offer_descriptor(pick_op(phase_kind_e'(ph % 4)), pick_stamp(), pick_tag());
      end
      if (ph == 8) begin
        // Pause the sender until every outstanding answer has arrived.
        @(negedge clk_i);
        in_ch.valid <= 1'b0;
        wait (pending == 0);
      end
    end
    no_idle = 1'b0;

    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
